### sv/pd_servo_motor_model_top_macros.svh
// Assertion helpers for the servo block checker.
`ifndef PD_SERVO_MOTOR_MODEL_TOP_MACROS_SVH
`define PD_SERVO_MOTOR_MODEL_TOP_MACROS_SVH

// Clocked check, idle while reset is asserted.
`define PDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active during reset.
`define PDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pdservo_pkg.sv
package pdservo_pkg;

    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int DECAY_W    = 17;
    localparam int DECAY_BITS = 16;
    localparam int PROD_W     = 66;
    localparam int SUM_W      = 68;
    localparam int IDX_W      = 3;

    localparam logic [DECAY_W-1:0] DECAY_ONE        = 17'd65536;
    localparam logic [GAIN_W-1:0]  TORQUE_LIMIT_RST = 31'd655360;
    localparam logic [GAIN_W-1:0]  AMPS_PER_TQ_RST  = 31'd65536;
    localparam logic [GAIN_W-1:0]  TQ_PER_AMP_RST   = 31'd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_TORQUE_LIMIT = 3'd2,
        REG_AMPS_PER_TQ  = 3'd3,
        REG_CMD_DECAY    = 3'd4,
        REG_CUR_DECAY    = 3'd5,
        REG_TQ_PER_AMP   = 3'd6,
        REG_FRICTION     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [GAIN_W-1:0]  torque_limit;
        logic [GAIN_W-1:0]  amps_per_torque;
        logic [DECAY_W-1:0] command_decay;
        logic [DECAY_W-1:0] current_decay;
        logic [GAIN_W-1:0]  torque_per_amp;
        logic [GAIN_W-1:0]  friction_coeff;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_PD,
        ST_MUL_A,
        ST_DEM,
        ST_DIF1,
        ST_MUL_C,
        ST_LAG1,
        ST_DIF2,
        ST_MUL_W,
        ST_LAG2,
        ST_MUL_T,
        ST_MUL_R,
        ST_OUT,
        ST_CLR
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_P,
        OP_MUL_D,
        OP_PD,
        OP_MUL_A,
        OP_DEM,
        OP_DIF1,
        OP_MUL_C,
        OP_LAG1,
        OP_DIF2,
        OP_MUL_W,
        OP_LAG2,
        OP_MUL_T,
        OP_MUL_R,
        OP_OUT,
        OP_CLR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   mul_en;
    } dp_cmd_t;

    function automatic logic signed [SUM_W-1:0] sx32(input logic signed [DATA_W-1:0] v);
        return {{(SUM_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        lo = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        if (x > hi)
            return hi[DATA_W-1:0];
        else if (x < lo)
            return lo[DATA_W-1:0];
        else
            return x[DATA_W-1:0];
    endfunction

    // symmetric clamp to +/- lim
    function automatic logic signed [DATA_W-1:0] clamp_lim(input logic signed [SUM_W-1:0] x,
                                                          input logic [GAIN_W-1:0] lim);
        logic signed [SUM_W-1:0] pos;
        logic signed [SUM_W-1:0] neg;
        pos = {{(SUM_W-GAIN_W){1'b0}}, lim};
        neg = -pos;
        if (x > pos)
            return pos[DATA_W-1:0];
        else if (x < neg)
            return neg[DATA_W-1:0];
        else
            return x[DATA_W-1:0];
    endfunction

endpackage

### sv/pd_servo_motor_model_top.sv
// PD position servo with a two-stage first-order current lag.
//
// Input stream (s_*): one transfer per servo step. s_tuser selects the item
// kind (0 = control step, 1 = clear both currents); s_tdata carries target
// angle, measured angle and measured rate, all signed Q16.16.
// Output stream (m_*): exactly one transfer per input item, carrying the
// clamped joint torque and the updated motor current.
// Config port (cfg_*): register writes by index, always ready; write only
// while the block is idle.
//
// Schedule: a control step runs through its work states, ST_MUL_P to
// ST_MUL_R, on a single shared 34x32 multiplier (seven products), then
// is written to the output register in ST_OUT and presented on m_tvalid;
// no new item is taken until the sequencer is back in ST_IDLE. A clear
// item passes through ST_CLR and then shows its all-zero result.
// The output register holds a finished result while the input side accepts
// the next item; if the receiver still stalls when that item finishes, the
// sequencer waits and s_tready stays low. Reset clears both currents, the
// output valid and loads the register defaults.
module pd_servo_motor_model_top #(
    parameter int FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [3*pdservo_pkg::DATA_W-1:0]     s_tdata,   // target_angle, angle, rate
    input  logic [0:0]                           s_tuser,   // op
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [2*pdservo_pkg::DATA_W-1:0]     m_tdata,   // torque, motor_current
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdservo_pkg::IDX_W-1:0]        cfg_index,
    input  logic [pdservo_pkg::DATA_W-1:0]       cfg_data
);
    import pdservo_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    logic    out_free;

    pdservo_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: one step of the update per cycle, waiting in ST_OUT or ST_CLR while the output register is full
    pdservo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .clear_item (s_tuser[0]),
        .out_free   (out_free),
        .cmd        (cmd)
    );

    // shared multiplier, accumulator, lag state and output register
    pdservo_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

### sv/pdservo_regs.sv
module pdservo_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pdservo_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pdservo_pkg::DATA_W-1:0]  cfg_data,
    output pdservo_pkg::cfg_t               cfg
);
    import pdservo_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PROP_GAIN:    cfg_next.prop_gain       = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:   cfg_next.deriv_gain      = cfg_data[GAIN_W-1:0];
                REG_TORQUE_LIMIT: cfg_next.torque_limit    = cfg_data[GAIN_W-1:0];
                REG_AMPS_PER_TQ:  cfg_next.amps_per_torque = cfg_data[GAIN_W-1:0];
                REG_CMD_DECAY:    cfg_next.command_decay   = cfg_data[DECAY_W-1:0];
                REG_CUR_DECAY:    cfg_next.current_decay   = cfg_data[DECAY_W-1:0];
                REG_TQ_PER_AMP:   cfg_next.torque_per_amp  = cfg_data[GAIN_W-1:0];
                REG_FRICTION:     cfg_next.friction_coeff  = cfg_data[GAIN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= '0;
            cfg_reg.deriv_gain      <= '0;
            cfg_reg.torque_limit    <= TORQUE_LIMIT_RST;
            cfg_reg.amps_per_torque <= AMPS_PER_TQ_RST;
            cfg_reg.command_decay   <= '0;
            cfg_reg.current_decay   <= '0;
            cfg_reg.torque_per_amp  <= TQ_PER_AMP_RST;
            cfg_reg.friction_coeff  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/pdservo_ctrl.sv
module pdservo_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 clear_item,
    input  logic                 out_free,
    output pdservo_pkg::dp_cmd_t cmd
);
    import pdservo_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.mul_en = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = clear_item ? ST_CLR : ST_MUL_P;
                end
            end
            ST_MUL_P: begin cmd.op = OP_MUL_P; cmd.mul_en = 1'b1; state_next = ST_MUL_D; end
            ST_MUL_D: begin cmd.op = OP_MUL_D; cmd.mul_en = 1'b1; state_next = ST_PD;    end
            ST_PD:    begin cmd.op = OP_PD;                       state_next = ST_MUL_A; end
            ST_MUL_A: begin cmd.op = OP_MUL_A; cmd.mul_en = 1'b1; state_next = ST_DEM;   end
            ST_DEM:   begin cmd.op = OP_DEM;                      state_next = ST_DIF1;  end
            ST_DIF1:  begin cmd.op = OP_DIF1;                     state_next = ST_MUL_C; end
            ST_MUL_C: begin cmd.op = OP_MUL_C; cmd.mul_en = 1'b1; state_next = ST_LAG1;  end
            ST_LAG1:  begin cmd.op = OP_LAG1;                     state_next = ST_DIF2;  end
            ST_DIF2:  begin cmd.op = OP_DIF2;                     state_next = ST_MUL_W; end
            ST_MUL_W: begin cmd.op = OP_MUL_W; cmd.mul_en = 1'b1; state_next = ST_LAG2;  end
            ST_LAG2:  begin cmd.op = OP_LAG2;                     state_next = ST_MUL_T; end
            ST_MUL_T: begin cmd.op = OP_MUL_T; cmd.mul_en = 1'b1; state_next = ST_MUL_R; end
            ST_MUL_R: begin cmd.op = OP_MUL_R; cmd.mul_en = 1'b1; state_next = ST_OUT;   end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_CLR;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/pdservo_dp.sv
module pdservo_dp #(
    parameter int FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  pdservo_pkg::dp_cmd_t              cmd,
    input  pdservo_pkg::cfg_t                 cfg,
    input  logic [3*pdservo_pkg::DATA_W-1:0]  s_tdata,
    input  logic                              m_tready,
    output logic                              out_free,
    output logic                              m_tvalid,
    output logic [2*pdservo_pkg::DATA_W-1:0]  m_tdata
);
    import pdservo_pkg::*;

    // input operands
    logic signed [DATA_W-1:0] in_target;
    logic signed [DATA_W-1:0] in_angle;
    logic signed [DATA_W-1:0] in_rate;

    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] rate_reg;
    logic signed [DATA_W-1:0] pd_reg;
    logic signed [DATA_W-1:0] tgt_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // lag state
    logic signed [DATA_W-1:0] cmd_cur_reg;
    logic signed [DATA_W-1:0] win_cur_reg;

    // output register
    logic                     m_tvalid_reg;
    logic signed [DATA_W-1:0] torque_reg;
    logic signed [DATA_W-1:0] mcur_reg;

    // shared multiplier
    logic signed [DATA_W+1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic [DECAY_W-1:0]       cmd_decay;
    logic [DECAY_W-1:0]       cur_decay;

    logic signed [PROD_W-1:0] prod_f;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [SUM_W-1:0]  prod_fx;
    logic signed [SUM_W-1:0]  prod_dx;
    logic signed [SUM_W-1:0]  acc_x;
    logic signed [SUM_W-1:0]  acc_diff;
    logic signed [SUM_W-1:0]  lag_sum;
    logic signed [SUM_W-1:0]  err_sum;

    assign in_target = s_tdata[DATA_W-1:0];
    assign in_angle  = s_tdata[2*DATA_W-1:DATA_W];
    assign in_rate   = s_tdata[3*DATA_W-1:2*DATA_W];

    assign cmd_decay = (cfg.command_decay > DECAY_ONE) ? DECAY_ONE : cfg.command_decay;
    assign cur_decay = (cfg.current_decay > DECAY_ONE) ? DECAY_ONE : cfg.current_decay;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_P:
            begin
                mul_a = {{2{err_reg[DATA_W-1]}}, err_reg};
                mul_b = $signed({1'b0, cfg.prop_gain});
            end
            OP_MUL_D:
            begin
                mul_a = {{2{rate_reg[DATA_W-1]}}, rate_reg};
                mul_b = $signed({1'b0, cfg.deriv_gain});
            end
            OP_MUL_A:
            begin
                mul_a = {{2{pd_reg[DATA_W-1]}}, pd_reg};
                mul_b = $signed({1'b0, cfg.amps_per_torque});
            end
            OP_MUL_C:
            begin
                mul_a = {diff_reg[DATA_W], diff_reg};
                mul_b = $signed({{(DATA_W-DECAY_W){1'b0}}, cmd_decay});
            end
            OP_MUL_W:
            begin
                mul_a = {diff_reg[DATA_W], diff_reg};
                mul_b = $signed({{(DATA_W-DECAY_W){1'b0}}, cur_decay});
            end
            OP_MUL_T:
            begin
                mul_a = {{2{win_cur_reg[DATA_W-1]}}, win_cur_reg};
                mul_b = $signed({1'b0, cfg.torque_per_amp});
            end
            OP_MUL_R:
            begin
                mul_a = {{2{rate_reg[DATA_W-1]}}, rate_reg};
                mul_b = $signed({1'b0, cfg.friction_coeff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // floor shifts of the held product
    assign prod_f   = prod_reg >>> FRAC_BITS;
    assign prod_d   = prod_reg >>> DECAY_BITS;
    assign prod_fx  = {{(SUM_W-PROD_W){prod_f[PROD_W-1]}}, prod_f};
    assign prod_dx  = {{(SUM_W-PROD_W){prod_d[PROD_W-1]}}, prod_d};
    assign acc_x    = {{(SUM_W-PROD_W){acc_reg[PROD_W-1]}}, acc_reg};
    assign acc_diff = acc_x - prod_fx;
    assign lag_sum  = sx32(tgt_reg) + prod_dx;
    assign err_sum  = sx32(in_target) - sx32(in_angle);

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {mcur_reg, torque_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_p;

        case (cmd.op)
            OP_LOAD:
            begin
                err_reg  <= sat32(err_sum);
                rate_reg <= in_rate;
            end
            OP_MUL_D: acc_reg <= prod_f;
            OP_PD:    pd_reg  <= clamp_lim(acc_diff, cfg.torque_limit);
            OP_DEM:   tgt_reg <= sat32(prod_fx);
            OP_DIF1:  diff_reg <= {cmd_cur_reg[DATA_W-1], cmd_cur_reg}
                                - {tgt_reg[DATA_W-1], tgt_reg};
            OP_DIF2:
            begin
                diff_reg <= {win_cur_reg[DATA_W-1], win_cur_reg}
                          - {cmd_cur_reg[DATA_W-1], cmd_cur_reg};
                tgt_reg  <= cmd_cur_reg;
            end
            OP_MUL_R: acc_reg <= prod_f;
            OP_OUT:
            begin
                torque_reg <= clamp_lim(acc_diff, cfg.torque_limit);
                mcur_reg   <= win_cur_reg;
            end
            OP_CLR:
            begin
                torque_reg <= '0;
                mcur_reg   <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_cur_reg  <= '0;
            win_cur_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_LAG1)
                cmd_cur_reg <= sat32(lag_sum);
            else if (cmd.op == OP_CLR)
                cmd_cur_reg <= '0;

            if (cmd.op == OP_LAG2)
                win_cur_reg <= sat32(lag_sum);
            else if (cmd.op == OP_CLR)
                win_cur_reg <= '0;

            if (cmd.op == OP_OUT || cmd.op == OP_CLR)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

endmodule

### sv/pdservo_checker.sv
`include "pd_servo_motor_model_top_macros.svh"

module pdservo_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // held result stays put until taken
    `PDS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output changed while stalled")

    // one item in flight: input closes right after a transfer
    `PDS_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "input accepted back to back")

    // clear with a free output yields an all-zero result once ST_CLR has written the output register
    `PDS_ASSERT(a_clear_zero, s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> ##1 (m_tvalid && m_tdata == 64'h0), "clear result missing or nonzero")

    // nothing to deliver while held in reset
    `PDS_ASSERT_ALWAYS(a_rst_idle, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind pd_servo_motor_model_top pdservo_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/pd_servo_torque_checker.sv
`timescale 1ns / 1ps
module pd_servo_torque_checker
    import pdservo_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [3*DATA_W-1:0]     s_tdata,    // target_angle, angle, rate
    input  logic [0:0]              s_tuser,    // op
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [2*DATA_W-1:0]     m_tdata,    // torque, motor_current
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]       cfg_data,
    output int                      fail_count,
    output int                      pending
);

    localparam logic ITEM_CLEAR = 1'b1;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] motor_current;
        logic signed [DATA_W-1:0] torque;
    } servo_out_t;

    cfg_t                     regs;
    logic signed [DATA_W-1:0] cmd_cur;
    logic signed [DATA_W-1:0] wind_cur;
    servo_out_t               torque_due_q[$];

    function automatic longint sat_word(input longint x);
        if (x > WORD_MAX)
            return WORD_MAX;
        if (x < WORD_MIN)
            return WORD_MIN;
        return x;
    endfunction

    function automatic longint clamp_sym(input longint x, input logic [GAIN_W-1:0] lim);
        longint l;
        l = longint'(lim);
        if (x > l)
            return l;
        if (x < -l)
            return -l;
        return x;
    endfunction

    // first-order lag; decay saturates at 1.0
    function automatic logic signed [DATA_W-1:0] lag_to(input logic signed [DATA_W-1:0] old,
                                                        input logic signed [DATA_W-1:0] tgt,
                                                        input logic [DECAY_W-1:0] d);
        longint k;
        longint diff;
        k = (d > DECAY_ONE) ? longint'(DECAY_ONE) : longint'(d);
        diff = longint'(old) - longint'(tgt);
        return DATA_W'(sat_word(longint'(tgt) + ((diff * k) >>> DECAY_BITS)));
    endfunction

    function automatic servo_out_t servo_update(input logic signed [DATA_W-1:0] tgt,
                                                input logic signed [DATA_W-1:0] ang,
                                                input logic signed [DATA_W-1:0] rt);
        longint     err;
        longint     pd;
        longint     amps;
        longint     em;
        longint     fr;
        servo_out_t r;
        err  = sat_word(longint'(tgt) - longint'(ang));
        pd   = ((longint'(regs.prop_gain) * err) >>> FRAC_BITS)
             - ((longint'(regs.deriv_gain) * longint'(rt)) >>> FRAC_BITS);
        pd   = clamp_sym(pd, regs.torque_limit);
        amps = (pd * longint'(regs.amps_per_torque)) >>> FRAC_BITS;
        cmd_cur  = lag_to(cmd_cur, DATA_W'(sat_word(amps)), regs.command_decay);
        wind_cur = lag_to(wind_cur, cmd_cur, regs.current_decay);
        em = (longint'(regs.torque_per_amp) * longint'(wind_cur)) >>> FRAC_BITS;
        fr = (longint'(regs.friction_coeff) * longint'(rt)) >>> FRAC_BITS;
        r.torque        = DATA_W'(clamp_sym(em - fr, regs.torque_limit));
        r.motor_current = wind_cur;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        servo_out_t               due;
        logic signed [DATA_W-1:0] got_tq;
        logic signed [DATA_W-1:0] got_mc;
        if (!rst_n)
        begin
            regs.prop_gain       = '0;
            regs.deriv_gain      = '0;
            regs.torque_limit    = TORQUE_LIMIT_RST;
            regs.amps_per_torque = AMPS_PER_TQ_RST;
            regs.command_decay   = '0;
            regs.current_decay   = '0;
            regs.torque_per_amp  = TQ_PER_AMP_RST;
            regs.friction_coeff  = '0;
            cmd_cur    = '0;
            wind_cur   = '0;
            fail_count = 0;
            torque_due_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_PROP_GAIN:    regs.prop_gain       = cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:   regs.deriv_gain      = cfg_data[GAIN_W-1:0];
                    REG_TORQUE_LIMIT: regs.torque_limit    = cfg_data[GAIN_W-1:0];
                    REG_AMPS_PER_TQ:  regs.amps_per_torque = cfg_data[GAIN_W-1:0];
                    REG_CMD_DECAY:    regs.command_decay   = cfg_data[DECAY_W-1:0];
                    REG_CUR_DECAY:    regs.current_decay   = cfg_data[DECAY_W-1:0];
                    REG_TQ_PER_AMP:   regs.torque_per_amp  = cfg_data[GAIN_W-1:0];
                    REG_FRICTION:     regs.friction_coeff  = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            // results are retired before a new item is queued
            if (m_tvalid && m_tready)
            begin
                got_tq = m_tdata[DATA_W-1:0];
                got_mc = m_tdata[2*DATA_W-1:DATA_W];
                if (torque_due_q.size() == 0)
                begin
                    $error("unexpected result: torque %0d motor_current %0d", got_tq, got_mc);
                    fail_count++;
                end
                else
                begin
                    due = torque_due_q.pop_front();
                    if (got_tq !== due.torque)
                    begin
                        $error("torque: expected %0d, got %0d", due.torque, got_tq);
                        fail_count++;
                    end
                    if (got_mc !== due.motor_current)
                    begin
                        $error("motor_current: expected %0d, got %0d",
                               due.motor_current, got_mc);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == ITEM_CLEAR)
                begin
                    cmd_cur  = '0;
                    wind_cur = '0;
                    due      = '0;
                end
                else
                    due = servo_update(s_tdata[DATA_W-1:0], s_tdata[2*DATA_W-1:DATA_W],
                                       s_tdata[3*DATA_W-1:2*DATA_W]);
                torque_due_q.push_back(due);
            end
        end
        pending = torque_due_q.size();
    end

endmodule

### sim/pd_servo_motor_model_top_tb.sv
`timescale 1ns / 1ps
module pd_servo_motor_model_top_tb;
    import pdservo_pkg::*;

    localparam int   FRAC_BITS   = 16;
    localparam int   ONE         = 1 << FRAC_BITS;     // 1.0 in Q16.16
    localparam int   IDLE_LIMIT  = 4000;               // cycles with no transfer at all
    localparam int   PHASES      = 8;
    localparam int   PHASE_ITEMS = 200;
    localparam int   TAIL_CYCLES = 40;
    localparam logic ITEM_STEP   = 1'b0;
    localparam logic ITEM_CLEAR  = 1'b1;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
    localparam logic [DECAY_W-1:0] DECAY_ALL = '1;     // above 1.0, reads as 1.0

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [3*DATA_W-1:0]   s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [DATA_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit gap_on;        // sender inserts idle cycles between items
    bit stall_on;      // receiver drops m_tready at random

    pd_servo_motor_model_top #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pd_servo_torque_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Idle lengths: mostly from the short range, now and then a long hole.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int next_gap();
        if (gap_on && $urandom_range(0, 2) == 0)
            return pick_gap();
        return 0;
    endfunction

    // Receiver back-pressure, driven on the falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic cfg_t make_cfg(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] d,
                                      input logic [GAIN_W-1:0] lim,
                                      input logic [GAIN_W-1:0] apt,
                                      input logic [DECAY_W-1:0] cd,
                                      input logic [DECAY_W-1:0] wd,
                                      input logic [GAIN_W-1:0] tpa,
                                      input logic [GAIN_W-1:0] fric);
        cfg_t c;
        c.prop_gain       = p;
        c.deriv_gain      = d;
        c.torque_limit    = lim;
        c.amps_per_torque = apt;
        c.command_decay   = cd;
        c.current_decay   = wd;
        c.torque_per_amp  = tpa;
        c.friction_coeff  = fric;
        return c;
    endfunction

    // Gains mostly in a usable range (0..4.0), some anywhere, some at the ends.
    function automatic logic [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return GAIN_W'($urandom_range(0, 4 * ONE));
        if (r < 85)
            return GAIN_W'($urandom);
        return (r < 92) ? '0 : GAIN_MAX;
    endfunction

    function automatic logic [DECAY_W-1:0] rand_decay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return DECAY_W'($urandom_range(0, ONE));
        if (r < 80)
            return (r < 70) ? '0 : DECAY_ONE;
        return DECAY_W'($urandom_range(ONE + 1, 2 * ONE - 1));
    endfunction

    function automatic cfg_t rand_cfg();
        logic [GAIN_W-1:0] lim;
        lim = ($urandom_range(0, 4) == 0) ? rand_gain() : GAIN_W'($urandom_range(0, 50 * ONE));
        return make_cfg(rand_gain(), rand_gain(), lim, rand_gain(), rand_decay(),
                        rand_decay(), rand_gain(), rand_gain());
    endfunction

    // Writes every register back to back; unused upper data bits are random.
    // Called on a falling edge with the block idle.
    task automatic load_config(input cfg_t c);
        logic [DATA_W-1:0] word;
        for (int i = 0; i < 8; i++)
        begin
            word = $urandom;
            case (reg_idx_t'(i))
                REG_PROP_GAIN:    word[GAIN_W-1:0]  = c.prop_gain;
                REG_DERIV_GAIN:   word[GAIN_W-1:0]  = c.deriv_gain;
                REG_TORQUE_LIMIT: word[GAIN_W-1:0]  = c.torque_limit;
                REG_AMPS_PER_TQ:  word[GAIN_W-1:0]  = c.amps_per_torque;
                REG_CMD_DECAY:    word[DECAY_W-1:0] = c.command_decay;
                REG_CUR_DECAY:    word[DECAY_W-1:0] = c.current_decay;
                REG_TQ_PER_AMP:   word[GAIN_W-1:0]  = c.torque_per_amp;
                REG_FRICTION:     word[GAIN_W-1:0]  = c.friction_coeff;
                default: ;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= word;
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // One input transfer. tvalid stays high into the next item when no gap
    // follows; end_burst drops it once a run of items is done.
    task automatic send_item(input logic op, input logic [DATA_W-1:0] tgt,
                             input logic [DATA_W-1:0] ang, input logic [DATA_W-1:0] rt);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {rt, ang, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Sender holds off until every queued result has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        logic              op;
        logic [DATA_W-1:0] tgt;
        logic [DATA_W-1:0] ang;
        logic [DATA_W-1:0] rt;

        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        gap_on     = 1'b0;
        stall_on   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: zero gains, so only a zero torque can come out.
        send_item(ITEM_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_item(ITEM_CLEAR, '0, '0, '0);
        end_burst();
        drain();

        // Moderate loop: error saturation both ways, rate extremes, clear
        // carrying junk in its data fields.
        gap_on   = 1'b1;
        stall_on = 1'b1;
        load_config(make_cfg(GAIN_W'(2 * ONE), GAIN_W'(ONE / 2), GAIN_W'(10 * ONE),
                             GAIN_W'(ONE), DECAY_W'(32768), DECAY_W'(49152),
                             GAIN_W'(ONE), GAIN_W'(ONE / 4)));
        send_item(ITEM_STEP, ONE, '0, '0);
        send_item(ITEM_STEP, 32'h7FFF_FFFF, 32'h8000_0000, '0);
        send_item(ITEM_STEP, 32'h8000_0000, 32'h7FFF_FFFF, '0);
        send_item(ITEM_STEP, '0, '0, 32'h7FFF_FFFF);
        send_item(ITEM_STEP, '0, '0, 32'h8000_0000);
        send_item(ITEM_STEP, -ONE, ONE, ONE);
        send_item(ITEM_CLEAR, 32'hFFFF_FFFF, 32'h1234_5678, 32'hDEAD_BEEF);
        send_item(ITEM_STEP, 3 * ONE, '0, -ONE);
        send_item(ITEM_STEP, '0, '0, '0);
        send_item(ITEM_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        end_burst();
        drain();

        // Everything at its top: products at full width, decay above one.
        load_config(make_cfg(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, DECAY_ALL, DECAY_ALL,
                             GAIN_MAX, GAIN_MAX));
        send_item(ITEM_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_item(ITEM_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(ITEM_STEP, 32'hFFFF_FFFF, '0, 32'h0000_0001);
        send_item(ITEM_STEP, '0, 32'h0000_0001, 32'hFFFF_FFFF);
        end_burst();
        drain();

        // Zero clamp and no lag: torque pinned at zero whatever the gains.
        load_config(make_cfg(GAIN_MAX, GAIN_MAX, '0, GAIN_MAX, '0, '0, GAIN_MAX, GAIN_MAX));
        send_item(ITEM_STEP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_item(ITEM_STEP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(ITEM_STEP, ONE, '0, ONE);
        end_burst();
        drain();

        // Decay of exactly one: both lags freeze at their previous value.
        load_config(make_cfg(GAIN_W'(ONE), GAIN_W'(ONE), GAIN_W'(20 * ONE), GAIN_W'(2 * ONE),
                             DECAY_ONE, DECAY_ONE, GAIN_W'(ONE), GAIN_W'(ONE)));
        send_item(ITEM_STEP, 5 * ONE, '0, ONE);
        send_item(ITEM_STEP, -5 * ONE, '0, -ONE);
        send_item(ITEM_CLEAR, '0, '0, '0);
        end_burst();
        drain();

        // Random phases, each with its own register set and idle pattern.
        // The first one runs with no idling at all.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            gap_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
            stall_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            load_config(rand_cfg());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op = ($urandom_range(0, 19) == 0) ? ITEM_CLEAR : ITEM_STEP;
                if ($urandom_range(0, 4) == 0)
                begin
                    tgt = $urandom;
                    ang = $urandom;
                    rt  = $urandom;
                end
                else
                begin
                    // small error and rate keep the loop off the clamps
                    tgt = $urandom_range(0, 8 * ONE) - 4 * ONE;
                    ang = tgt + $urandom_range(0, 2 * ONE) - ONE;
                    rt  = $urandom_range(0, 4 * ONE) - 2 * ONE;
                end
                send_item(op, tgt, ang, rt);
                // mid-phase hold-off until the output side has caught up
                if (n == PHASE_ITEMS / 2)
                begin
                    end_burst();
                    drain();
                end
            end
            end_burst();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
